// ----- sv/csw_pkg.sv -----
package csw_pkg;

  localparam int FRAC_BITS = 16;   // fraction bits of curvatures and registers
  localparam int IFB       = 28;   // fraction bits of the internal ratios
  localparam int HQ        = 30;   // fraction bits of the polynomial terms

  localparam int CURV_W    = 32;
  localparam int REG_W     = 32;
  localparam int WEIGHT_W  = 17;
  localparam int CFG_IDX_W = 8;

  // divider: 60-bit dividend, 33-bit divisor, 32 quotient bits (one per stage)
  localparam int NUM_W = 60;
  localparam int DEN_W = 33;
  localparam int QUO_W = 32;

  localparam int ARG_W    = 31;    // Gaussian argument, at most 2^30
  localparam int FAC_W    = 17;    // factor in Q.16
  localparam int SQ_W     = 2 * QUO_W;
  localparam int T_W      = 34;    // z^2/2 in Q.28, at most 2^33
  localparam int TL_W     = 17;    // low half of t for the split multiply
  localparam int LOG_W    = 29;
  localparam int LPROD_W  = (T_W - TL_W) + LOG_W;
  localparam int WSUM_W   = TL_W + LPROD_W;
  localparam int NF_W     = WSUM_W - 2 * IFB;
  localparam int N_W      = 5;
  localparam int P_W      = 31;
  localparam int SH_W     = 6;

  localparam logic [QUO_W-1:0]   Z_MAX     = QUO_W'(8) << IFB;
  localparam logic [LOG_W-1:0]   LOG2E_Q28 = 29'd387270501;
  localparam logic [P_W-1:0]     C1_Q30    = 31'd744261118;
  localparam logic [P_W-1:0]     C2_Q30    = 31'd257941248;
  localparam logic [P_W-1:0]     C3_Q30    = 31'd59597083;
  localparam logic [P_W-1:0]     C4_Q30    = 31'd10327388;
  localparam logic [P_W-1:0]     ONE_Q30   = 31'd1073741824;
  localparam logic [NF_W-1:0]    N_LIMIT   = NF_W'(17);
  localparam logic [SH_W-1:0]    SH_BASE   = SH_W'(14);
  localparam logic [FAC_W-1:0]   FAC_ONE   = FAC_W'(1) << 16;

  localparam int HORNER_STEPS = 4;
  localparam int SQUARE_STEPS = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_SHAPE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_SIZE      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURVATURE_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_OFFSET    = 8'd3;

  typedef struct packed {
    logic kill;   // factor forced to zero
    logic zarg;   // argument is zero
    logic ovf;    // quotient does not fit
  } div_side_t;

  typedef struct packed {
    logic kill;
    logic one;
    logic zero;
  } fac_flag_t;

  // c - (g * p) >> 30
  function automatic logic [P_W-1:0] horner_step(input logic [IFB-1:0] g,
                                                 input logic [P_W-1:0] p,
                                                 input logic [P_W-1:0] c);
    logic [IFB+P_W-1:0] prod;
    prod = (IFB+P_W)'(g) * (IFB+P_W)'(p);
    return c - P_W'(prod >> HQ);
  endfunction

  function automatic logic [P_W-1:0] square_q30(input logic [P_W-1:0] p);
    logic [2*P_W-1:0] prod;
    prod = (2*P_W)'(p) * (2*P_W)'(p);
    return P_W'(prod >> HQ);
  endfunction

endpackage

// ----- sv/curvature_sphericity_weight.sv -----
// Sphericity weight of one mesh face from its two principal curvatures (signed Q16.16),
// returned in Q1.16 (0 to 65536). The weight is the product of a shape Gaussian over
// (k1-k2)/(max|k|+guard_offset) and a size Gaussian over 1 - min(min|k|/curvature_limit, 1).
// The pipeline accepts one item every cycle while the output is not stalled; its depth is set
// by two 32-stage restoring dividers in series (ratio, then division by sigma), plus front,
// argument, 10 exp stages and the output register. Stalls on the output hold the whole
// pipeline. Configuration writes take effect at once and are meant for an idle block;
// writes to an index past the four registers are dropped.
module curvature_sphericity_weight (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [csw_pkg::CURV_W-1:0] in_curv_first,
  input  logic signed [csw_pkg::CURV_W-1:0] in_curv_second,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [csw_pkg::WEIGHT_W-1:0]    out_weight,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [csw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csw_pkg::REG_W-1:0]       cfg_data
);
  import csw_pkg::*;

  logic [REG_W-1:0] sigma_shape_r;
  logic [REG_W-1:0] sigma_size_r;
  logic [REG_W-1:0] curvature_limit_r;
  logic [REG_W-1:0] guard_offset_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_shape_r     <= REG_W'(65536);
      sigma_size_r      <= REG_W'(65536);
      curvature_limit_r <= REG_W'(65536);
      guard_offset_r    <= REG_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIGMA_SHAPE:     sigma_shape_r     <= cfg_data;
        REG_SIGMA_SIZE:      sigma_size_r      <= cfg_data;
        REG_CURVATURE_LIMIT: curvature_limit_r <= cfg_data;
        REG_GUARD_OFFSET:    guard_offset_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  logic [WEIGHT_W-1:0] out_weight_r;

  assign adv      = out_ready | ~out_valid_r;
  assign in_ready = adv;

  // front stage: magnitudes, divisor and early-out tests
  logic signed [CURV_W:0] k1, k2, d;
  logic [CURV_W-1:0]      a1, a2, ad, mxa, mn;
  logic [DEN_W-1:0]       mx;
  logic [CURV_W+6:0]      mn_x100;
  div_side_t              shp_side_nxt, siz_side_nxt;

  assign k1  = (CURV_W+1)'(in_curv_first);
  assign k2  = (CURV_W+1)'(in_curv_second);
  assign d   = k1 - k2;
  assign a1  = k1[CURV_W] ? CURV_W'(-k1) : CURV_W'(k1);
  assign a2  = k2[CURV_W] ? CURV_W'(-k2) : CURV_W'(k2);
  assign ad  = d[CURV_W] ? CURV_W'(-d) : CURV_W'(d);
  assign mxa = (a1 > a2) ? a1 : a2;
  assign mn  = (a1 < a2) ? a1 : a2;
  assign mx  = DEN_W'(mxa) + DEN_W'(guard_offset_r);
  assign mn_x100 = (CURV_W+7)'(mn) * (CURV_W+7)'(100);

  // ratio above one half: d > 0 and 2d > divisor
  assign shp_side_nxt.kill = ~d[CURV_W] && (d != '0) && ({d[CURV_W-1:0], 1'b0} > mx);
  assign shp_side_nxt.zarg = (mx == '0);
  assign shp_side_nxt.ovf  = 1'b0;
  assign siz_side_nxt.kill = (mn_x100 <= (CURV_W+7)'(curvature_limit_r));
  assign siz_side_nxt.zarg = (mn >= curvature_limit_r);
  assign siz_side_nxt.ovf  = 1'b0;

  logic              fr_vld_r;
  logic [CURV_W-1:0] fr_ad_r;
  logic [DEN_W-1:0]  fr_mx_r;
  logic [CURV_W-1:0] fr_mn_r;
  div_side_t         fr_shp_side_r;
  div_side_t         fr_siz_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (adv) begin
      fr_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fr_ad_r       <= ad;
      fr_mx_r       <= mx;
      fr_mn_r       <= mn;
      fr_shp_side_r <= shp_side_nxt;
      fr_siz_side_r <= siz_side_nxt;
    end
  end

  // ratio dividers, Q.28 results
  logic             shp_dvld, siz_dvld;
  logic [QUO_W-1:0] shp_q, siz_q;
  div_side_t        shp_dside, siz_dside;

  csw_div u_div_shape (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (fr_vld_r),
    .num      (NUM_W'(fr_ad_r) << IFB),
    .den      (fr_mx_r),
    .side     (fr_shp_side_r),
    .out_vld  (shp_dvld),
    .quo      (shp_q),
    .side_out (shp_dside)
  );

  csw_div u_div_size (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (fr_vld_r),
    .num      (NUM_W'(fr_mn_r) << IFB),
    .den      (DEN_W'(curvature_limit_r)),
    .side     (fr_siz_side_r),
    .out_vld  (siz_dvld),
    .quo      (siz_q),
    .side_out (siz_dside)
  );

  // argument stage
  logic [IFB:0]     u_full;
  logic             ag_vld_r;
  logic [ARG_W-1:0] ag_x_r;
  logic [ARG_W-1:0] ag_u_r;
  logic             ag_kill_shp_r;
  logic             ag_kill_siz_r;

  assign u_full = ((IFB+1)'(1) << IFB) - (IFB+1)'(siz_q[IFB-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ag_vld_r <= 1'b0;
    end else if (adv) begin
      ag_vld_r <= shp_dvld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ag_x_r        <= shp_dside.zarg ? '0 : ARG_W'(shp_q);
      ag_u_r        <= siz_dside.zarg ? '0 : ARG_W'(u_full);
      ag_kill_shp_r <= shp_dside.kill;
      ag_kill_siz_r <= siz_dside.kill;
    end
  end

  logic             gs_vld, gz_vld;
  logic [FAC_W-1:0] f_shape, f_size;

  csw_gauss u_gauss_shape (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (ag_vld_r),
    .arg     (ag_x_r),
    .kill    (ag_kill_shp_r),
    .sigma   (sigma_shape_r),
    .out_vld (gs_vld),
    .fac     (f_shape)
  );

  csw_gauss u_gauss_size (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (ag_vld_r),
    .arg     (ag_u_r),
    .kill    (ag_kill_siz_r),
    .sigma   (sigma_size_r),
    .out_vld (gz_vld),
    .fac     (f_size)
  );

  // output register: product of the two factors, rounded to Q1.16
  logic [2*FAC_W-1:0] wprod;
  logic [2*FAC_W-1:0] wsum;

  assign wprod = (2*FAC_W)'(f_shape) * (2*FAC_W)'(f_size);
  assign wsum  = wprod + (2*FAC_W)'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= gs_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_weight_r <= wsum[16 +: WEIGHT_W];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_weight = out_weight_r;

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    shp_dvld == siz_dvld)
    else $error("ratio dividers out of step");

  a_gauss_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    gs_vld == gz_vld)
    else $error("exp pipelines out of step");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weight <= (WEIGHT_W'(1) << 16)))
    else $error("weight above one");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    gs_vld |-> (f_shape <= FAC_ONE && f_size <= FAC_ONE))
    else $error("factor above one");

endmodule

// ----- sv/csw_div.sv -----
module csw_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic [csw_pkg::NUM_W-1:0]  num,
  input  logic [csw_pkg::DEN_W-1:0]  den,
  input  csw_pkg::div_side_t         side,
  output logic                       out_vld,
  output logic [csw_pkg::QUO_W-1:0]  quo,
  output csw_pkg::div_side_t         side_out
);
  import csw_pkg::*;

  logic [DEN_W-1:0] rem_r  [QUO_W];
  logic [QUO_W-1:0] lo_r   [QUO_W];
  logic [DEN_W-1:0] den_r  [QUO_W];
  div_side_t        side_r [QUO_W];
  logic             vld_r  [QUO_W];

  // restoring division, one quotient bit per stage; quotient bits shift into lo
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W-1:0] rem_s;
    logic [DEN_W-1:0] den_s;
    logic [QUO_W-1:0] lo_s;
    div_side_t        side_s;
    logic             vld_s;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_s  = DEN_W'(num[NUM_W-1:QUO_W]);
      assign lo_s   = num[QUO_W-1:0];
      assign den_s  = den;
      assign side_s = side;
      assign vld_s  = in_vld;
    end else begin : g_next
      assign rem_s  = rem_r[k-1];
      assign lo_s   = lo_r[k-1];
      assign den_s  = den_r[k-1];
      assign side_s = side_r[k-1];
      assign vld_s  = vld_r[k-1];
    end

    assign trial = {rem_s, lo_s[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_s};
    assign diff  = trial - {1'b0, den_s};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo_r[k]   <= {lo_s[QUO_W-2:0], ge};
        den_r[k]  <= den_s;
        side_r[k] <= side_s;
      end
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign quo      = lo_r[QUO_W-1];
  assign side_out = side_r[QUO_W-1];

endmodule

// ----- sv/csw_gauss.sv -----
module csw_gauss (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic [csw_pkg::ARG_W-1:0]  arg,
  input  logic                       kill,
  input  logic [csw_pkg::REG_W-1:0]  sigma,
  output logic                       out_vld,
  output logic [csw_pkg::FAC_W-1:0]  fac
);
  import csw_pkg::*;

  logic [NUM_W-1:0] num;
  div_side_t        side_in;
  div_side_t        dside;
  logic             dvld;
  logic [QUO_W-1:0] dq;

  assign num          = NUM_W'(arg) << FRAC_BITS;
  assign side_in.kill = kill;
  assign side_in.zarg = (arg == '0);
  // quotient would need more than 32 bits (also catches a zero sigma)
  assign side_in.ovf  = (REG_W'(num[NUM_W-1:QUO_W]) >= sigma);

  csw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_vld),
    .num      (num),
    .den      ({1'b0, sigma}),
    .side     (side_in),
    .out_vld  (dvld),
    .quo      (dq),
    .side_out (dside)
  );

  // stage 1: t = z^2 / 2
  logic [SQ_W-1:0] z_sq;
  fac_flag_t       s1_flg_nxt;
  logic            s1_vld_r;
  fac_flag_t       s1_flg_r;
  logic [T_W-1:0]  s1_t_r;

  assign z_sq            = SQ_W'(dq) * SQ_W'(dq);
  assign s1_flg_nxt.kill = dside.kill;
  assign s1_flg_nxt.one  = dside.zarg;
  assign s1_flg_nxt.zero = dside.ovf | (dq > Z_MAX);

  // stage 2: t * log2(e), split in two partial products
  logic               s2_vld_r;
  fac_flag_t          s2_flg_r;
  logic [LPROD_W-1:0] s2_ph_r;
  logic [LPROD_W-1:0] s2_pl_r;

  // stage 3: w = n + g
  logic [WSUM_W-1:0] wsum;
  logic [NF_W-1:0]   n_full;
  fac_flag_t         s3_flg_nxt;
  logic              s3_vld_r;
  fac_flag_t         s3_flg_r;
  logic [IFB-1:0]    s3_g_r;
  logic [N_W-1:0]    s3_n_r;

  assign wsum            = (WSUM_W'(s2_ph_r) << TL_W) + WSUM_W'(s2_pl_r);
  assign n_full          = wsum[WSUM_W-1:2*IFB];
  assign s3_flg_nxt.kill = s2_flg_r.kill;
  assign s3_flg_nxt.one  = s2_flg_r.one;
  assign s3_flg_nxt.zero = s2_flg_r.zero | (n_full >= N_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= dvld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flg_r <= s1_flg_nxt;
      s1_t_r   <= z_sq[IFB+1 +: T_W];
      s2_flg_r <= s1_flg_r;
      s2_ph_r  <= LPROD_W'(s1_t_r[T_W-1:TL_W]) * LPROD_W'(LOG2E_Q28);
      s2_pl_r  <= LPROD_W'(s1_t_r[TL_W-1:0]) * LPROD_W'(LOG2E_Q28);
      s3_flg_r <= s3_flg_nxt;
      s3_g_r   <= wsum[2*IFB-1:IFB];
      s3_n_r   <= n_full[N_W-1:0];
    end
  end

  // Horner steps for 2^(-g/4)
  logic [P_W-1:0] horner_c [HORNER_STEPS];
  assign horner_c[0] = C3_Q30;
  assign horner_c[1] = C2_Q30;
  assign horner_c[2] = C1_Q30;
  assign horner_c[3] = ONE_Q30;

  logic [P_W-1:0] hp_r [HORNER_STEPS];
  logic [IFB-1:0] hg_r [HORNER_STEPS];
  logic [N_W-1:0] hn_r [HORNER_STEPS];
  fac_flag_t      hf_r [HORNER_STEPS];
  logic           hv_r [HORNER_STEPS];

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    logic [P_W-1:0] p_s;
    logic [IFB-1:0] g_s;
    logic [N_W-1:0] n_s;
    fac_flag_t      f_s;
    logic           v_s;

    if (k == 0) begin : g_first
      assign p_s = C4_Q30;
      assign g_s = s3_g_r;
      assign n_s = s3_n_r;
      assign f_s = s3_flg_r;
      assign v_s = s3_vld_r;
    end else begin : g_next
      assign p_s = hp_r[k-1];
      assign g_s = hg_r[k-1];
      assign n_s = hn_r[k-1];
      assign f_s = hf_r[k-1];
      assign v_s = hv_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hv_r[k] <= 1'b0;
      end else if (adv) begin
        hv_r[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hp_r[k] <= horner_step(g_s, p_s, horner_c[k]);
        hg_r[k] <= g_s;
        hn_r[k] <= n_s;
        hf_r[k] <= f_s;
      end
    end
  end

  // two squarings take 2^(-g/4) to 2^(-g)
  logic [P_W-1:0] sp_r [SQUARE_STEPS];
  logic [N_W-1:0] sn_r [SQUARE_STEPS];
  fac_flag_t      sf_r [SQUARE_STEPS];
  logic           sv_r [SQUARE_STEPS];

  for (genvar k = 0; k < SQUARE_STEPS; k++) begin : g_square
    logic [P_W-1:0] p_s;
    logic [N_W-1:0] n_s;
    fac_flag_t      f_s;
    logic           v_s;

    if (k == 0) begin : g_first
      assign p_s = hp_r[HORNER_STEPS-1];
      assign n_s = hn_r[HORNER_STEPS-1];
      assign f_s = hf_r[HORNER_STEPS-1];
      assign v_s = hv_r[HORNER_STEPS-1];
    end else begin : g_next
      assign p_s = sp_r[k-1];
      assign n_s = sn_r[k-1];
      assign f_s = sf_r[k-1];
      assign v_s = sv_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (adv) begin
        sv_r[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sp_r[k] <= square_q30(p_s);
        sn_r[k] <= n_s;
        sf_r[k] <= f_s;
      end
    end
  end

  // last stage: shift by 14+n with rounding half up, then the special cases
  logic [SH_W-1:0]  shamt;
  logic [P_W:0]     rnd_sum;
  logic [FAC_W-1:0] fac_nxt;
  logic             fac_vld_r;
  logic [FAC_W-1:0] fac_r;
  fac_flag_t        lf;

  assign lf      = sf_r[SQUARE_STEPS-1];
  assign shamt   = SH_BASE + SH_W'(sn_r[SQUARE_STEPS-1]);
  assign rnd_sum = (P_W+1)'(sp_r[SQUARE_STEPS-1]) + ((P_W+1)'(1) << (shamt - SH_W'(1)));

  always_comb begin
    priority if (lf.kill) begin
      fac_nxt = '0;
    end else if (lf.one) begin
      fac_nxt = FAC_ONE;
    end else if (lf.zero) begin
      fac_nxt = '0;
    end else begin
      fac_nxt = FAC_W'(rnd_sum >> shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fac_vld_r <= 1'b0;
    end else if (adv) begin
      fac_vld_r <= sv_r[SQUARE_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fac_r <= fac_nxt;
    end
  end

  assign out_vld = fac_vld_r;
  assign fac     = fac_r;

endmodule
